// File: rtl/adjacent_hit_clusterer_defines.svh
// Assertion macros shared by the checker of the adjacent hit clusterer.
`ifndef ADJACENT_HIT_CLUSTERER_DEFINES_SVH
`define ADJACENT_HIT_CLUSTERER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define AHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adjacent_hit_clusterer check failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define AHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adjacent_hit_clusterer check failed");

`endif

// File: rtl/ahc_pkg.sv
// Package with the types and constants of the adjacent hit clusterer.
`default_nettype none

package ahc_pkg;

    // Field widths.
    localparam int CHANNEL_W   = 10;
    localparam int TIME_W      = 16;
    localparam int SIG_W       = 8;
    localparam int POS_W       = 13;
    localparam int HITS_W      = 11;
    localparam int SUM_W       = 21;
    localparam int HALF_W      = 12;
    localparam int CALC_W      = 16;

    // Geometry of the plane.
    localparam int CHANNELS     = 1024;
    localparam int MODULE_WIRES = 8;
    localparam int MODULE_PITCH = 2 * MODULE_WIRES + 1;
    localparam int WIRE_W       = $clog2(CHANNELS);

    // Saturation limits.
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};
    localparam logic signed [CALC_W-1:0] POS_MAX = 16'sd4095;
    localparam logic signed [CALC_W-1:0] POS_MIN = -16'sd4096;

    // Centroid divider: quotient bits retired per cycle and cycle count.
    localparam int DIV_RADIX = 3;
    localparam int DIV_STEPS = (SUM_W + DIV_RADIX - 1) / DIV_RADIX;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Depth of the queue between the front and the back.
    localparam int AHC_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [TIME_W-1:0]    hit_time;
        logic [SIG_W-1:0]     signature;
        logic                 last_in_event;
    } hit_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position_half;
        logic [HITS_W-1:0]       hit_count;
        logic [TIME_W-1:0]       last_time;
        logic [SIG_W-1:0]        last_signature;
        logic                    end_of_event;
    } cluster_t;

    // A closed cluster waiting for its centroid.
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [HITS_W-1:0] hits;
        logic [TIME_W-1:0] last_time;
        logic [SIG_W-1:0]  last_signature;
        logic              end_of_event;
    } emit_req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/ahc_front.sv
// Front of the clusterer: takes hits, grows clusters and queues closed ones.
`default_nettype none

module ahc_front
    import ahc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire hit_t      hit,
    input  wire logic      q_full,
    output logic           q_wr,
    output emit_req_t      q_data
);

    logic [SUM_W-1:0]     sum_reg,  sum_next;
    logic [HITS_W-1:0]    hits_reg, hits_next;
    logic [CHANNEL_W-1:0] prev_ch_reg;
    logic [TIME_W-1:0]    prev_time_reg;
    logic [SIG_W-1:0]     prev_sig_reg;
    logic                 open_reg;
    logic                 pend_valid_reg;
    emit_req_t            pend_reg;

    logic                 accept;
    logic [CHANNEL_W-1:0] ch_diff;
    logic [SIG_W-1:0]     sig_diff;
    logic                 joins;
    logic                 emit_old;
    logic [SUM_W:0]       sum_grown;
    emit_req_t            req_old;
    emit_req_t            req_new;

    // A hit is refused while a second request is held back or the queue is full.
    assign full   = pend_valid_reg || q_full;
    assign accept = push && !full;

    // Adjacency test against the previous hit.
    always_comb
    begin
        ch_diff  = (hit.channel >= prev_ch_reg) ? hit.channel - prev_ch_reg
                                                : prev_ch_reg - hit.channel;
        sig_diff = (hit.signature >= prev_sig_reg) ? hit.signature - prev_sig_reg
                                                   : prev_sig_reg - hit.signature;
        joins    = open_reg && (ch_diff < CHANNEL_W'(2)) && (sig_diff < SIG_W'(2));
        emit_old = open_reg && !joins;
    end

    // Cluster sums after this hit, saturating.
    always_comb
    begin
        sum_grown = {1'b0, sum_reg} + (SUM_W + 1)'(hit.channel);
        if (joins)
        begin
            sum_next  = sum_grown[SUM_W] ? SUM_MAX : sum_grown[SUM_W-1:0];
            hits_next = (hits_reg == HITS_MAX) ? hits_reg : hits_reg + HITS_W'(1);
        end
        else
        begin
            sum_next  = SUM_W'(hit.channel);
            hits_next = HITS_W'(1);
        end
    end

    // The cluster that this hit closes, and the one it ends at event end.
    always_comb
    begin
        req_old.sum            = sum_reg;
        req_old.hits           = hits_reg;
        req_old.last_time      = prev_time_reg;
        req_old.last_signature = prev_sig_reg;
        req_old.end_of_event   = 1'b0;
        req_new.sum            = sum_next;
        req_new.hits           = hits_next;
        req_new.last_time      = hit.hit_time;
        req_new.last_signature = hit.signature;
        req_new.end_of_event   = 1'b1;
    end

    // Queue write: a held-back request goes first, else the hit's own.
    always_comb
    begin
        q_wr   = 1'b0;
        q_data = req_old;
        if (pend_valid_reg)
        begin
            q_wr   = !q_full;
            q_data = pend_reg;
        end
        else if (accept && emit_old)
        begin
            q_wr   = 1'b1;
            q_data = req_old;
        end
        else if (accept && hit.last_in_event)
        begin
            q_wr   = 1'b1;
            q_data = req_new;
        end
    end

    // Cluster state and the held-back request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            hits_reg       <= '0;
            prev_ch_reg    <= '0;
            prev_time_reg  <= '0;
            prev_sig_reg   <= '0;
            open_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pend_valid_reg && !q_full)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                prev_ch_reg   <= hit.channel;
                prev_time_reg <= hit.hit_time;
                prev_sig_reg  <= hit.signature;
                if (hit.last_in_event)
                begin
                    open_reg <= 1'b0;
                    sum_reg  <= '0;
                    hits_reg <= '0;
                end
                else
                begin
                    open_reg <= 1'b1;
                    sum_reg  <= sum_next;
                    hits_reg <= hits_next;
                end
                if (emit_old && hit.last_in_event)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload of the held-back request needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept && emit_old && hit.last_in_event)
        begin
            pend_reg <= req_new;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ahc_fifo.sv
// Short queue of closed clusters between the front and the back.
`default_nettype none

module ahc_fifo
    import ahc_pkg::*;
#(
    parameter int DEPTH = AHC_FIFO_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire emit_req_t wr_data,
    output logic           q_full,
    input  wire logic      rd,
    output emit_req_t      rd_data,
    output logic           q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    emit_req_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = store_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ahc_back.sv
// Back of the clusterer: centroid divide, plane mapping and result register.
`default_nettype none

module ahc_back
    import ahc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire emit_req_t         q_data,
    output logic                   q_rd,
    input  wire logic              cfg_write,
    input  wire logic [HALF_W-1:0] cfg_data,
    output logic                   empty,
    input  wire logic              pop,
    output cluster_t               cluster
);

    back_state_t         state_reg, state_next;
    logic [SUM_W-1:0]    num_reg;
    logic [HITS_W:0]     rem_reg;
    logic [HITS_W-1:0]   div_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [HITS_W-1:0]   hits_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [SIG_W-1:0]    sig_reg;
    logic                eoe_reg;
    logic [HALF_W-1:0]   half_reg;
    logic                out_valid_reg;
    cluster_t            cluster_reg;

    logic                load_out;
    logic [SUM_W-1:0]    num_step;
    logic [HITS_W:0]     rem_step;
    logic [WIRE_W-1:0]   wire_idx;
    logic [WIRE_W-1:0]   module_idx;
    logic [WIRE_W-1:0]   wire_offs;
    logic [CALC_W-1:0]   pos_base;
    logic signed [CALC_W-1:0] pos_wide;
    logic signed [POS_W-1:0]  pos_sat;

    assign empty   = !out_valid_reg;
    assign cluster = cluster_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= '0;
        end
        else if (cfg_write)
        begin
            half_reg <= cfg_data;
        end
    end

    // Restoring division, several quotient bits per cycle.
    always_comb
    begin
        rem_step = rem_reg;
        num_step = num_reg;
        for (int i = 0; i < DIV_RADIX; i++)
        begin
            rem_step = {rem_step[HITS_W-1:0], num_step[SUM_W-1]};
            num_step = {num_step[SUM_W-2:0], 1'b0};
            if (rem_step >= {1'b0, div_reg})
            begin
                rem_step    = rem_step - {1'b0, div_reg};
                num_step[0] = 1'b1;
            end
        end
    end

    // Clamp the centroid and map it onto modules with a half-wire gap.
    always_comb
    begin
        wire_idx   = (num_reg > SUM_W'(CHANNELS - 1)) ? WIRE_W'(CHANNELS - 1)
                                                      : num_reg[WIRE_W-1:0];
        module_idx = wire_idx / WIRE_W'(MODULE_WIRES);
        wire_offs  = wire_idx % WIRE_W'(MODULE_WIRES);
        pos_base   = CALC_W'(module_idx) * CALC_W'(MODULE_PITCH)
                   + (CALC_W'(wire_offs) << 1);
        pos_wide   = signed'(pos_base) - signed'(CALC_W'(half_reg));
        if (pos_wide > POS_MAX)
        begin
            pos_sat = POS_MAX[POS_W-1:0];
        end
        else if (pos_wide < POS_MIN)
        begin
            pos_sat = POS_MIN[POS_W-1:0];
        end
        else
        begin
            pos_sat = pos_wide[POS_W-1:0];
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and control.
    always_comb
    begin
        state_next = state_reg;
        q_rd       = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Divider datapath and cluster fields carried alongside.
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            num_reg  <= q_data.sum;
            rem_reg  <= '0;
            div_reg  <= (q_data.hits == '0) ? HITS_W'(1) : q_data.hits;
            step_reg <= STEP_W'(DIV_STEPS - 1);
            hits_reg <= q_data.hits;
            time_reg <= q_data.last_time;
            sig_reg  <= q_data.last_signature;
            eoe_reg  <= q_data.end_of_event;
        end
        else if (state_reg == BK_DIVIDE)
        begin
            num_reg  <= num_step;
            rem_reg  <= rem_step;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // Result register: holds a cluster until it is popped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            cluster_reg.position_half  <= pos_sat;
            cluster_reg.hit_count      <= hits_reg;
            cluster_reg.last_time      <= time_reg;
            cluster_reg.last_signature <= sig_reg;
            cluster_reg.end_of_event   <= eoe_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/adjacent_hit_clusterer.sv
// A closed cluster passes through the queue, the centroid divider and the result register.
// Hits are taken one per cycle while the queue has room; a hit that
// closes two clusters holds the input until its second cluster is queued.
// The back works on one cluster at a time and reads the next only once the result is loaded.
// Reset is asynchronous and active low; it empties the queue and clears the open cluster.
`default_nettype none

module adjacent_hit_clusterer
    import ahc_pkg::*;
#(
    parameter int FIFO_DEPTH = AHC_FIFO_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire hit_t              hit,
    output logic                   empty,
    input  wire logic              pop,
    output cluster_t               cluster,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [HALF_W-1:0] cfg_data
);

    logic      q_full;
    logic      q_empty;
    logic      q_wr;
    logic      q_rd;
    emit_req_t q_wr_data;
    emit_req_t q_rd_data;

    // The configuration register takes every request at once.
    assign cfg_ready = 1'b1;

    // Front: cluster building.
    ahc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .hit    (hit),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_wr_data)
    );

    // Queue of closed clusters.
    ahc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // Back: centroid and position.
    ahc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_rd      (q_rd),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .cluster   (cluster)
    );

endmodule

`default_nettype wire

// File: rtl/ahc_checker.sv
// Port-level checker of the adjacent hit clusterer and its bind.
`default_nettype none
`include "adjacent_hit_clusterer_defines.svh"

module ahc_checker
    import ahc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire logic              pop,
    input  wire cluster_t          cluster,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready
);

    // A waiting result stays and holds its value until it is popped.
    `AHC_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(cluster))

    // Every delivered cluster holds at least one hit.
    `AHC_ASSERT_NOW(a_count_nonzero, !empty, cluster.hit_count != '0)

    // The configuration register never refuses a request.
    `AHC_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind adjacent_hit_clusterer ahc_checker u_checker (.*);

`default_nettype wire
